/* hw/rtl/erpr_pkg.sv */
// ----------------------------------------------------------------------------
// erpr_pkg
// Shared types and codes for the elimination tree row pattern reach block.
// ----------------------------------------------------------------------------
package erpr_pkg;

	// request codes carried on req_type
	localparam logic REQ_LOAD    = 1'b0;
	localparam logic REQ_NONZERO = 1'b1;

	// mark epoch tag: a node is marked when its tag equals the live epoch;
	// tag zero is what the sweep writes and is never live
	localparam int                 EPOCH_W     = 6;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} erpr_state_t;

endpackage

/* hw/rtl/erpr_ram.sv */
// ----------------------------------------------------------------------------
// erpr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module erpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hw/rtl/etree_row_pattern_reach_top.sv */
// ----------------------------------------------------------------------------
// etree_row_pattern_reach_top
// Row pattern of a sparse Cholesky factor by climbing the elimination tree.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | beat contents
//  ---------+----------------------------+---------------------------------------
//  item     | item_valid / item_stall    | req_type, parent_slot, parent_value,
//           |                            | column_index, row_index,
//           |                            | first_in_column, last_in_column
//  result   | result_valid / result_stall| pattern_node, path_end, tree_error
//
//  A load beat writes one parent entry. A nonzero beat is accepted, then the walk
//  marks one node per step, plus a last step that either finds the marked node
//  ending the climb or flushes the last node after a root. A row above the column
//  starts no walk; for a row already marked the walk ends at its first step.
//  Each walk step reads the mark tag and parent of one node (registered-read RAMs);
//  a marked node is emitted once it is known whether it ends the path.
//  Marks clear by bumping the epoch tag. Reset, and every 63rd clear, sweeps the
//  mark RAM to zero, with item beats stalled. The parent RAM is
//  not cleared and must be loaded before it is walked.
//  A stall on the result side holds the walk where it stands; item beats are
//  stalled while a walk or a sweep is running.
//
module etree_row_pattern_reach_top
	import erpr_pkg::*;
#(
	parameter int NODES = 64
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              item_valid,
	output logic              item_stall,
	input  logic              req_type,
	input  logic [5:0]        parent_slot,
	input  logic signed [6:0] parent_value,
	input  logic [5:0]        column_index,
	input  logic [5:0]        row_index,
	input  logic              first_in_column,
	input  logic              last_in_column,

	output logic              result_valid,
	input  logic              result_stall,
	output logic [5:0]        pattern_node,
	output logic              path_end,
	output logic              tree_error
);

	localparam int            NW      = $clog2(NODES);
	localparam logic [6:0]    NodesW  = 7'(NODES);
	localparam logic [NW-1:0] ClrLast = NW'(NODES - 1);

	// ------------------------------------------------------------------
	// state
	// ------------------------------------------------------------------
	erpr_state_t        state_q, state_d;
	logic [NW-1:0]      node_q, node_d;      // node whose tag and parent are read
	logic               last_q, last_d;      // clear marks when this walk ends
	logic [NW-1:0]      pend_q, pend_d;      // marked node not yet emitted
	logic               pend_v_q, pend_v_d;
	logic               fwd_q, fwd_d;        // node_q was marked as it was read
	logic [EPOCH_W-1:0] epoch_q, epoch_d;    // live mark tag
	logic [NW-1:0]      clr_q, clr_d;        // sweep address

	logic               out_valid_q;
	logic [5:0]         pattern_node_q;
	logic               path_end_q;
	logic               tree_error_q;

	// ------------------------------------------------------------------
	// parent table and mark tag RAMs, read at the same node
	// ------------------------------------------------------------------
	logic               par_wr_en;
	logic               mark_wr_en;
	logic [NW-1:0]      mark_wr_addr;
	logic [EPOCH_W-1:0] mark_wr_data;
	logic               rd_en;
	logic [NW-1:0]      rd_addr;
	logic [6:0]         parent_rd;
	logic [EPOCH_W-1:0] mark_rd;

	erpr_ram #(
		.WIDTH (7),
		.DEPTH (NODES)
	) u_parent_ram (
		.clk     (clk),
		.wr_en   (par_wr_en),
		.wr_addr (parent_slot[NW-1:0]),
		.wr_data (parent_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (parent_rd)
	);

	erpr_ram #(
		.WIDTH (EPOCH_W),
		.DEPTH (NODES)
	) u_mark_ram (
		.clk     (clk),
		.wr_en   (mark_wr_en),
		.wr_addr (mark_wr_addr),
		.wr_data (mark_wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (mark_rd)
	);

	// ------------------------------------------------------------------
	// decode of the incoming beat
	// ------------------------------------------------------------------
	logic          slot_ok;
	logic          col_ok;
	logic          row_ok;
	logic [NW-1:0] col_idx;
	logic [NW-1:0] row_idx;

	assign slot_ok = ({1'b0, parent_slot} < NodesW);
	assign col_ok  = ({1'b0, column_index} < NodesW);
	assign row_ok  = (row_index <= column_index) && ({1'b0, row_index} < NodesW);
	assign col_idx = column_index[NW-1:0];
	assign row_idx = row_index[NW-1:0];

	// ------------------------------------------------------------------
	// walk step: tag and parent of node_q are on the RAM outputs
	// ------------------------------------------------------------------
	logic          node_hit;   // node_q already marked
	logic          p_err;      // root or out-of-range parent
	logic [NW-1:0] p_idx;
	logic          out_free;
	logic          bump;       // clear the marks

	assign node_hit = (mark_rd == epoch_q) || fwd_q;
	assign p_err    = parent_rd[6] || (parent_rd >= NodesW);
	assign p_idx    = parent_rd[NW-1:0];
	assign out_free = !out_valid_q || !result_stall;

	logic       out_load;
	logic [5:0] out_node;
	logic       out_end;
	logic       out_err;

	always_comb begin
		state_d      = state_q;
		node_d       = node_q;
		last_d       = last_q;
		pend_d       = pend_q;
		pend_v_d     = pend_v_q;
		fwd_d        = fwd_q;
		epoch_d      = epoch_q;
		clr_d        = clr_q;
		par_wr_en    = 1'b0;
		mark_wr_en   = 1'b0;
		mark_wr_addr = node_q;
		mark_wr_data = epoch_q;
		rd_en        = 1'b0;
		rd_addr      = row_idx;
		out_load     = 1'b0;
		out_node     = 6'(pend_q);
		out_end      = 1'b0;
		out_err      = 1'b0;
		bump         = 1'b0;
		item_stall   = (state_q != ST_IDLE);

		case (state_q)
			ST_CLEAR: begin
				mark_wr_en   = 1'b1;
				mark_wr_addr = clr_q;
				mark_wr_data = '0;
				clr_d        = clr_q + 1'b1;
				if (clr_q == ClrLast) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					if (req_type == REQ_LOAD) begin
						par_wr_en = slot_ok;
					end else begin
						if (first_in_column && col_ok) begin
							mark_wr_en   = 1'b1;
							mark_wr_addr = col_idx;
						end
						if (row_ok) begin
							// fetch tag and parent of the row node
							rd_en    = 1'b1;
							rd_addr  = row_idx;
							node_d   = row_idx;
							last_d   = last_in_column;
							pend_v_d = 1'b0;
							fwd_d    = first_in_column && col_ok && (col_idx == row_idx);
							state_d  = ST_WALK;
						end else begin
							bump = last_in_column;
						end
					end
				end
			end
			ST_WALK: begin
				if (out_free) begin
					if (node_hit) begin
						// climb met a marked node: the pending node closes the path
						out_load = pend_v_q;
						out_end  = 1'b1;
						state_d  = ST_IDLE;
						bump     = last_q;
					end else begin
						out_load     = pend_v_q;
						mark_wr_en   = 1'b1;
						mark_wr_addr = node_q;
						pend_d       = node_q;
						pend_v_d     = 1'b1;
						if (p_err) begin
							state_d = ST_FLUSH;
						end else begin
							// climb: fetch the parent's tag and parent
							rd_en   = 1'b1;
							rd_addr = p_idx;
							node_d  = p_idx;
							fwd_d   = (p_idx == node_q);
						end
					end
				end
			end
			ST_FLUSH: begin
				// root reached: last node carries the error
				if (out_free) begin
					out_load = 1'b1;
					out_end  = 1'b1;
					out_err  = 1'b1;
					state_d  = ST_IDLE;
					bump     = last_q;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (bump) begin
			if (epoch_q == EPOCH_LAST) begin
				// tags would wrap: sweep the mark RAM first
				epoch_d = EPOCH_FIRST;
				clr_d   = '0;
				state_d = ST_CLEAR;
			end else begin
				epoch_d = epoch_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			last_q   <= 1'b0;
			pend_v_q <= 1'b0;
			epoch_q  <= EPOCH_FIRST;
			clr_q    <= '0;
		end else begin
			state_q  <= state_d;
			last_q   <= last_d;
			pend_v_q <= pend_v_d;
			epoch_q  <= epoch_d;
			clr_q    <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_d;
		pend_q <= pend_d;
		fwd_q  <= fwd_d;
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pattern_node_q <= out_node;
			path_end_q     <= out_end;
			tree_error_q   <= out_err;
		end
	end

	assign result_valid = out_valid_q;
	assign pattern_node = pattern_node_q;
	assign path_end     = path_end_q;
	assign tree_error   = tree_error_q;

`ifndef SYNTHESIS
	// an error result always closes its path
	a_err_ends_path: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && tree_error_q) |-> path_end_q)
		else $error("tree_error without path_end");

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_stall) |=>
		(out_valid_q && $stable(pattern_node_q) && $stable(path_end_q)))
		else $error("stalled result beat changed");

	// the flush always has a node to emit
	a_flush_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> pend_v_q)
		else $error("flush without a pending node");

	// the swept tag is never live
	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("mark epoch is zero");
`endif

endmodule

/* test/tb_etree_row_pattern_reach_top.sv */
// ----------------------------------------------------------------------------
// tb_etree_row_pattern_reach_top
// Self-checking bench for the elimination tree row pattern reach block.
// Loads parent tables and streams column nonzeros. A behavioral climb of the
// tree predicts every emitted node, and each result beat is checked against
// the oldest prediction. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_etree_row_pattern_reach_top;
	import erpr_pkg::*;

	localparam int NODES          = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 8;

	// one input beat, field for field
	typedef struct packed {
		logic              req;
		logic [5:0]        slot;
		logic signed [6:0] pval;
		logic [5:0]        col;
		logic [5:0]        row;
		logic              first;
		logic              last;
	} etree_item_t;

	// one emitted pattern node
	typedef struct packed {
		logic [5:0] node;
		logic       path_end;
		logic       tree_error;
	} pattern_beat_t;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	logic              req_type;
	logic [5:0]        parent_slot;
	logic signed [6:0] parent_value;
	logic [5:0]        column_index;
	logic [5:0]        row_index;
	logic              first_in_column;
	logic              last_in_column;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [5:0]        pattern_node;
	logic              path_end;
	logic              tree_error;

	// shadow of the block: parent table and visited marks
	logic [6:0]    parent_tab [NODES];
	bit            node_mark  [NODES];
	pattern_beat_t pattern_fifo [$];
	pattern_beat_t head_beat;

	int mismatches  = 0;
	int idle_cycles = 0;
	bit calm        = 1'b0;   // no gaps or stalls while set

	etree_row_pattern_reach_top #(
		.NODES(NODES)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.req_type        (req_type),
		.parent_slot     (parent_slot),
		.parent_value    (parent_value),
		.column_index    (column_index),
		.row_index       (row_index),
		.first_in_column (first_in_column),
		.last_in_column  (last_in_column),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.pattern_node    (pattern_node),
		.path_end        (path_end),
		.tree_error      (tree_error)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// receiver stalls at random, 27 percent of the time, unless calm
	always @(negedge clk) begin
		result_stall <= !calm && ($urandom_range(0, 99) < 27);
	end

	// Climb from the row toward the root, marking and emitting each unmarked
	// node. The walk ends at a marked node, or at a root (negative or out of
	// range parent), which flags tree_error on the last node.
	task automatic climb_etree(input etree_item_t it);
		pattern_beat_t path [$];
		logic [5:0]    node;
		logic [6:0]    up;
		bit            broke;
		if (it.req == REQ_LOAD) begin
			parent_tab[it.slot] = it.pval;
			return;
		end
		if (it.first)
			node_mark[it.col] = 1'b1;
		if (it.row <= it.col) begin
			node  = it.row;
			broke = 1'b0;
			while (!node_mark[node]) begin
				node_mark[node] = 1'b1;
				path.push_back(pattern_beat_t'{node: node, path_end: 1'b0, tree_error: 1'b0});
				up = parent_tab[node];
				if (up[6] || up >= NODES) begin
					broke = 1'b1;
					break;
				end
				node = up[5:0];
			end
			if (path.size() > 0) begin
				path[path.size() - 1].path_end   = 1'b1;
				path[path.size() - 1].tree_error = broke;
			end
			foreach (path[i])
				pattern_fifo.push_back(path[i]);
		end
		// last flag clears marks even when the row was above the column
		if (it.last)
			node_mark = '{default: 1'b0};
	endtask

	// ignored fields get random content
	function automatic etree_item_t load_item(int slot, int value);
		etree_item_t it;
		logic [31:0] r;
		r        = $urandom;
		it       = r[$bits(etree_item_t)-1:0];
		it.req   = REQ_LOAD;
		it.slot  = 6'(slot);
		it.pval  = 7'(value);
		return it;
	endfunction

	function automatic etree_item_t nonzero_item(int k, int row, bit first, bit last);
		etree_item_t it;
		logic [31:0] r;
		r        = $urandom;
		it       = r[$bits(etree_item_t)-1:0];
		it.req   = REQ_NONZERO;
		it.col   = 6'(k);
		it.row   = 6'(row);
		it.first = first;
		it.last  = last;
		return it;
	endfunction

	// Drive one beat at the falling edge, hold it until accepted, then
	// update the shadow. Random gaps come before the beat unless calm.
	task automatic send_item(input etree_item_t it);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 27) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid      <= 1'b1;
		req_type        <= it.req;
		parent_slot     <= it.slot;
		parent_value    <= it.pval;
		column_index    <= it.col;
		row_index       <= it.row;
		first_in_column <= it.first;
		last_in_column  <= it.last;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		climb_etree(it);
	endtask

	// sender holds off until every predicted node has come out
	task automatic wait_pattern_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pattern_fifo.size() != 0)
			@(posedge clk);
	endtask

	// parent[j] = j+1, 63 is the root: the deepest possible walk
	task automatic load_chain_tree();
		for (int j = 0; j < NODES; j++)
			send_item(load_item(j, (j == NODES - 1) ? -1 : j + 1));
	endtask

	// well-formed forest: parents lie above their children
	task automatic load_random_forest();
		int p;
		for (int j = 0; j < NODES; j++) begin
			p = j + int'($urandom_range(1, 4));
			if (p >= NODES || $urandom_range(0, 7) == 0)
				p = -1;
			send_item(load_item(j, p));
		end
	endtask

	// directed walks over the chain tree
	task automatic test_directed_walks();
		send_item(nonzero_item(63, 0, 1, 1));   // full climb, stops at marked 63
		send_item(nonzero_item(63, 0, 0, 1));   // full climb into the root
		send_item(nonzero_item(5, 5, 1, 0));    // row already marked
		send_item(nonzero_item(5, 6, 0, 0));    // row above column
		send_item(nonzero_item(5, 2, 0, 0));
		send_item(nonzero_item(5, 0, 0, 1));    // stops on nodes of the prior path
		send_item(load_item(10, -1));           // cut the chain at 10
		send_item(nonzero_item(20, 3, 1, 0));   // reaches the new root
		send_item(nonzero_item(20, 12, 0, 1));
		send_item(load_item(10, 11));
		send_item(load_item(0, 0));             // self loop
		send_item(nonzero_item(0, 0, 0, 1));
		send_item(load_item(0, 1));
		send_item(nonzero_item(30, 28, 1, 0));
		send_item(nonzero_item(30, 25, 1, 0));  // first again keeps the marks
		send_item(nonzero_item(30, 40, 0, 1));  // row above column still clears
		send_item(nonzero_item(30, 29, 0, 1));
		send_item(load_item(63, 63));           // largest parent value, self loop
		send_item(nonzero_item(63, 63, 0, 1));
		send_item(load_item(63, -1));
		send_item(nonzero_item(0, 0, 1, 1));
	endtask

	// Columns of one to six nonzeros with random rows, mostly well-formed:
	// first flag on the opening beat, last flag on the closing one. A few
	// flags are flipped and a few parent entries are rewritten at random.
	task automatic test_random_columns(input int n_items);
		int sent;
		int k;
		int nnz;
		int row;
		bit first;
		bit last;
		sent = 0;
		load_random_forest();
		while (sent < n_items) begin
			if ($urandom_range(0, 3) == 0)
				k = $urandom_range(0, NODES - 1);
			else
				k = $urandom_range(NODES / 2, NODES - 1);
			nnz = $urandom_range(1, 6);
			for (int i = 0; i < nnz; i++) begin
				if (i == 0 && $urandom_range(0, 2) == 0)
					row = k;
				else if ($urandom_range(0, 9) == 0)
					row = $urandom_range(0, NODES - 1);
				else
					row = $urandom_range(0, k);
				first = (i == 0);
				last  = (i == nnz - 1);
				if ($urandom_range(0, 19) == 0)
					first = !first;
				if ($urandom_range(0, 19) == 0)
					last = !last;
				send_item(nonzero_item(k, row, first, last));
				sent++;
			end
			if ($urandom_range(0, 11) == 0) begin
				send_item(load_item($urandom_range(0, NODES - 1),
					int'($urandom_range(0, NODES)) - 1));
				sent++;
			end
			if ($urandom_range(0, 15) == 0)
				wait_pattern_drained();
		end
	endtask

	// anything goes: backward parents, cycles, random flags
	task automatic test_table_noise(input int n_items);
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 1) == 0)
				send_item(load_item($urandom_range(0, NODES - 1),
					int'($urandom_range(0, NODES)) - 1));
			else
				send_item(nonzero_item($urandom_range(0, NODES - 1),
					$urandom_range(0, NODES - 1), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1))));
		end
	endtask

	// result check and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid === 1'b1 && !result_stall) begin
				if (pattern_fifo.size() == 0) begin
					$error("result beat with none pending: pattern_node %0d", pattern_node);
					mismatches++;
				end else begin
					head_beat = pattern_fifo.pop_front();
					if (pattern_node !== head_beat.node) begin
						$error("pattern_node expected %0d got %0d", head_beat.node,
							pattern_node);
						mismatches++;
					end
					if (path_end !== head_beat.path_end) begin
						$error("path_end expected %0b got %0b", head_beat.path_end,
							path_end);
						mismatches++;
					end
					if (tree_error !== head_beat.tree_error) begin
						$error("tree_error expected %0b got %0b", head_beat.tree_error,
							tree_error);
						mismatches++;
					end
				end
			end
			if ((item_valid && !item_stall) || (result_valid === 1'b1 && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_etree_row_pattern_reach_top NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		item_valid      = 1'b0;
		req_type        = REQ_LOAD;
		parent_slot     = '0;
		parent_value    = '0;
		column_index    = '0;
		row_index       = '0;
		first_in_column = 1'b0;
		last_in_column  = 1'b0;
		node_mark       = '{default: 1'b0};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every parent entry is written before any walk reads it
		load_chain_tree();
		test_directed_walks();
		wait_pattern_drained();
		test_random_columns(100);
		wait_pattern_drained();
		calm = 1'b1;
		test_random_columns(50);
		calm = 1'b0;
		test_table_noise(30);

		wait_pattern_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_etree_row_pattern_reach_top OK");
		else
			$display("tb_etree_row_pattern_reach_top NOT OK");
		$finish;
	end

endmodule

/* etree_row_pattern_reach_top.f */
hw/rtl/erpr_pkg.sv
hw/rtl/erpr_ram.sv
hw/rtl/etree_row_pattern_reach_top.sv
test/tb_etree_row_pattern_reach_top.sv
